>>> design/ckpl_pkg.sv
// Shared constants, codes and controller/datapath interface types for the pixel labeler.
package ckpl_pkg;

    localparam int MAX_REGIONS  = 4096;
    localparam int MAX_TERRAINS = 64;
    localparam int COLOUR_W     = 24;
    localparam int RCOL_W       = 32;
    localparam int VAR_W        = 8;
    localparam int RA_W         = $clog2(MAX_REGIONS);
    localparam int TA_W         = $clog2(MAX_TERRAINS);
    localparam int CNT_W        = RA_W + 1;
    localparam int TC_W         = TA_W + 1;
    localparam int REG_RAM_W    = COLOUR_W + 1;
    localparam int TER_RAM_W    = COLOUR_W + VAR_W;

    typedef enum logic [1:0] {
        FUNC_ADD_REGION,
        FUNC_ADD_TERRAIN,
        FUNC_PIXEL,
        FUNC_FINISH
    } t_func;

    typedef enum logic [2:0] {
        STAT_OK,
        STAT_REGION_FULL,
        STAT_INVALID,
        STAT_DUPLICATE,
        STAT_TERRAIN_FULL
    } t_status;

    typedef enum logic [1:0] {
        SCAN_TERRAIN,
        SCAN_REGION,
        SCAN_SWEEP
    } t_scan;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAUNCH,
        S_SCAN_T,
        S_SCAN_R,
        S_SWEEP,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic  load;
        logic  start;
        t_scan mode;
        logic  commit;
    } t_cmd;

    typedef struct packed {
        logic  done;
        t_func func;
    } t_stat;

endpackage

>>> design/ckpl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ckpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/ckpl_ctrl.sv
// Controller state machine that sequences table scans, sweeps and the result commit.
module ckpl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ckpl_pkg::t_stat i_stat,
    output ckpl_pkg::t_cmd  o_cmd,
    output logic          o_busy
);
    import ckpl_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.start  = 1'b0;
        o_cmd.mode   = SCAN_TERRAIN;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LAUNCH;
                end
            end
            S_LAUNCH: begin
                o_cmd.start = 1'b1;
                case (i_stat.func)
                    FUNC_ADD_REGION: begin
                        o_cmd.mode = SCAN_REGION;
                        n_state    = S_SCAN_R;
                    end
                    FUNC_FINISH: begin
                        o_cmd.mode = SCAN_SWEEP;
                        n_state    = S_SWEEP;
                    end
                    default: begin
                        o_cmd.mode = SCAN_TERRAIN;
                        n_state    = S_SCAN_T;
                    end
                endcase
            end
            S_SCAN_T: begin
                if (i_stat.done) begin
                    if (i_stat.func == FUNC_PIXEL) begin
                        o_cmd.start = 1'b1;
                        o_cmd.mode  = SCAN_REGION;
                        n_state     = S_SCAN_R;
                    end else begin
                        n_state = S_COMMIT;
                    end
                end
            end
            S_SCAN_R, S_SWEEP: begin
                if (i_stat.done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

>>> design/ckpl_dpath.sv
// Datapath: colour tables, scan engine, sticky flags and result registers.
module ckpl_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ckpl_pkg::t_cmd              i_cmd,
    output ckpl_pkg::t_stat             o_stat,
    input  logic [1:0]                  i_func,
    input  logic [ckpl_pkg::RCOL_W-1:0]   i_region_colour,
    input  logic [ckpl_pkg::COLOUR_W-1:0] i_terrain_colour,
    input  logic [ckpl_pkg::VAR_W-1:0]    i_terrain_variant,
    output logic                        o_done,
    output logic [2:0]                  o_status,
    output logic [ckpl_pkg::CNT_W-1:0]    o_region_index,
    output logic [ckpl_pkg::VAR_W-1:0]    o_variant_out,
    output logic                        o_region_unknown,
    output logic                        o_terrain_unknown,
    output logic [ckpl_pkg::CNT_W-1:0]    o_missing_count,
    output logic                        o_frame_ok
);
    import ckpl_pkg::*;

    t_func               r_func;
    logic [RCOL_W-1:0]   r_rcol;
    logic [COLOUR_W-1:0] r_tcol;
    logic [VAR_W-1:0]    r_tvar;

    logic [CNT_W-1:0]    r_rcount;
    logic [TC_W-1:0]     r_tcount;
    logic                r_any_r_unk, r_any_t_unk;

    logic                r_scan, r_skip, r_pend;
    t_scan               r_mode;
    logic [CNT_W-1:0]    r_raddr, r_pidx;
    logic [CNT_W-1:0]    r_missing;

    logic                r_thit, r_rhit;
    logic [TA_W-1:0]     r_tidx;
    logic [VAR_W-1:0]    r_tfound;
    logic [CNT_W-1:0]    r_ridx;

    logic                r_done;
    t_status             r_status;
    logic [CNT_W-1:0]    r_oidx, r_omiss;
    logic [VAR_W-1:0]    r_ovar;
    logic                r_orunk, r_otunk, r_ook;

    logic [REG_RAM_W-1:0] reg_rd, reg_wd;
    logic [TER_RAM_W-1:0] ter_rd, ter_wd;
    logic [RA_W-1:0]      reg_wa;
    logic [TA_W-1:0]      ter_wa;
    logic                 reg_we, ter_we;

    logic             invalid, rfull, tfull, skip_now, hit_now, scan_done, issue;
    logic [CNT_W-1:0] limit;

    assign invalid = (r_rcol == '0) || (r_rcol[RCOL_W-1:COLOUR_W] != '0);
    assign rfull   = (r_rcount >= CNT_W'(MAX_REGIONS));
    assign tfull   = (r_tcount >= TC_W'(MAX_TERRAINS));

    always_comb begin
        case (i_cmd.mode)
            SCAN_TERRAIN: begin
                skip_now = (r_tcount == '0);
            end
            SCAN_REGION: begin
                skip_now = (r_rcount == '0) || invalid ||
                           ((r_func == FUNC_ADD_REGION) && rfull);
            end
            default: begin
                skip_now = (r_rcount == '0);
            end
        endcase
    end

    assign limit   = (r_mode == SCAN_TERRAIN) ? CNT_W'(r_tcount) : r_rcount;
    assign hit_now = (r_mode == SCAN_TERRAIN) ? (ter_rd[COLOUR_W-1:0] == r_tcol)
                                              : (reg_rd[COLOUR_W-1:0] == r_rcol[COLOUR_W-1:0]);
    assign scan_done = r_scan && (r_skip || (r_pend &&
                       (((r_mode != SCAN_SWEEP) && hit_now) ||
                        (r_pidx == CNT_W'(limit - 1'b1)))));
    assign issue = r_scan && !r_skip && !scan_done && (r_raddr < limit);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= t_func'(i_func);
            r_rcol <= i_region_colour;
            r_tcol <= i_terrain_colour;
            r_tvar <= i_terrain_variant;
        end
        if (i_cmd.start) begin
            r_mode    <= i_cmd.mode;
            r_skip    <= skip_now;
            r_raddr   <= '0;
            r_missing <= '0;
        end else if (issue) begin
            r_raddr <= CNT_W'(r_raddr + 1'b1);
        end
        r_pidx <= r_raddr;
        if (r_scan && r_pend && (r_mode == SCAN_SWEEP) && !reg_rd[COLOUR_W]) begin
            r_missing <= CNT_W'(r_missing + 1'b1);
        end
        if (scan_done) begin
            if (r_mode == SCAN_TERRAIN) begin
                r_thit   <= !r_skip && hit_now;
                r_tidx   <= r_pidx[TA_W-1:0];
                r_tfound <= ter_rd[TER_RAM_W-1:COLOUR_W];
            end else begin
                r_rhit <= !r_skip && hit_now;
                r_ridx <= r_pidx;
            end
        end
        if (i_cmd.commit) begin
            r_status <= STAT_OK;
            r_oidx   <= '0;
            r_ovar   <= '0;
            r_orunk  <= 1'b0;
            r_otunk  <= 1'b0;
            r_omiss  <= '0;
            r_ook    <= 1'b0;
            case (r_func)
                FUNC_ADD_REGION: begin
                    if (rfull) begin
                        r_status <= STAT_REGION_FULL;
                    end else if (invalid) begin
                        r_status <= STAT_INVALID;
                    end else if (r_rhit) begin
                        r_status <= STAT_DUPLICATE;
                    end else begin
                        r_oidx <= CNT_W'(r_rcount + 1'b1);
                    end
                end
                FUNC_ADD_TERRAIN: begin
                    if (!r_thit && tfull) begin
                        r_status <= STAT_TERRAIN_FULL;
                    end
                end
                FUNC_PIXEL: begin
                    r_ovar  <= r_thit ? r_tfound : '0;
                    r_otunk <= !r_thit;
                    r_oidx  <= r_rhit ? CNT_W'(r_ridx + 1'b1) : '0;
                    r_orunk <= !r_rhit;
                end
                default: begin
                    r_orunk <= r_any_r_unk;
                    r_otunk <= r_any_t_unk;
                    r_omiss <= r_missing;
                    r_ook   <= !r_any_r_unk && !r_any_t_unk && (r_missing == '0);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rcount    <= '0;
            r_tcount    <= '0;
            r_any_r_unk <= 1'b0;
            r_any_t_unk <= 1'b0;
            r_scan      <= 1'b0;
            r_pend      <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_done <= i_cmd.commit;
            if (i_cmd.start) begin
                r_scan <= 1'b1;
                r_pend <= 1'b0;
            end else begin
                if (scan_done) begin
                    r_scan <= 1'b0;
                end
                r_pend <= issue;
            end
            if (i_cmd.commit) begin
                case (r_func)
                    FUNC_ADD_REGION: begin
                        if (!rfull && !invalid && !r_rhit) begin
                            r_rcount <= CNT_W'(r_rcount + 1'b1);
                        end
                    end
                    FUNC_ADD_TERRAIN: begin
                        if (!r_thit && !tfull) begin
                            r_tcount <= TC_W'(r_tcount + 1'b1);
                        end
                    end
                    FUNC_PIXEL: begin
                        if (!r_thit) begin
                            r_any_t_unk <= 1'b1;
                        end
                        if (!r_rhit) begin
                            r_any_r_unk <= 1'b1;
                        end
                    end
                    default: begin
                        r_any_r_unk <= 1'b0;
                        r_any_t_unk <= 1'b0;
                    end
                endcase
            end
        end
    end

    // Region write port: sweep clears seen bits, pixel sets one, add writes a new entry.
    always_comb begin
        reg_we = 1'b0;
        reg_wa = r_pidx[RA_W-1:0];
        reg_wd = {1'b0, reg_rd[COLOUR_W-1:0]};
        if (r_scan && r_pend && (r_mode == SCAN_SWEEP)) begin
            reg_we = 1'b1;
        end else if (i_cmd.commit && (r_func == FUNC_PIXEL) && r_rhit) begin
            reg_we = 1'b1;
            reg_wa = r_ridx[RA_W-1:0];
            reg_wd = {1'b1, r_rcol[COLOUR_W-1:0]};
        end else if (i_cmd.commit && (r_func == FUNC_ADD_REGION) &&
                     !rfull && !invalid && !r_rhit) begin
            reg_we = 1'b1;
            reg_wa = r_rcount[RA_W-1:0];
            reg_wd = {1'b0, r_rcol[COLOUR_W-1:0]};
        end
    end

    always_comb begin
        ter_wd = {r_tvar, r_tcol};
        ter_wa = r_thit ? r_tidx : r_tcount[TA_W-1:0];
        ter_we = i_cmd.commit && (r_func == FUNC_ADD_TERRAIN) && (r_thit || !tfull);
    end

    ckpl_ram #(.WIDTH(REG_RAM_W), .DEPTH(MAX_REGIONS)) u_region_ram (
        .i_clk   (i_clk),
        .i_we    (reg_we),
        .i_waddr (reg_wa),
        .i_wdata (reg_wd),
        .i_raddr (r_raddr[RA_W-1:0]),
        .o_rdata (reg_rd)
    );

    ckpl_ram #(.WIDTH(TER_RAM_W), .DEPTH(MAX_TERRAINS)) u_terrain_ram (
        .i_clk   (i_clk),
        .i_we    (ter_we),
        .i_waddr (ter_wa),
        .i_wdata (ter_wd),
        .i_raddr (r_raddr[TA_W-1:0]),
        .o_rdata (ter_rd)
    );

    assign o_stat.done       = scan_done;
    assign o_stat.func       = r_func;
    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_region_index    = r_oidx;
    assign o_variant_out     = r_ovar;
    assign o_region_unknown  = r_orunk;
    assign o_terrain_unknown = r_otunk;
    assign o_missing_count   = r_omiss;
    assign o_frame_ok        = r_ook;
endmodule

>>> design/colour_keyed_pixel_labeler.sv
// Top level of the colour-keyed pixel labeler: controller plus datapath.
//
//  Channel  | Handshake         | Payload
//  ---------+-------------------+--------------------------------------------------
//  command  | start / busy      | i_func, i_region_colour, i_terrain_colour,
//           |                   | i_terrain_variant
//  result   | o_done (strobe)   | o_status, o_region_index, o_variant_out,
//           |                   | o_region_unknown, o_terrain_unknown,
//           |                   | o_missing_count, o_frame_ok
//
// A command transfer happens on a rising edge with start high and busy low; busy
// then stays high through the launch state, the table scans and the commit state.
// A scan reads one entry per cycle from a table RAM and ends early on a hit; it is
// skipped when the table is empty or the region colour is invalid. A pixel scans
// the terrain table and then the region table, and a finish sweeps every stored
// region to count and clear its seen bit.
// The result strobe o_done comes in the cycle after commit, with busy low again, and
// the receiver cannot stall it. Reset is synchronous and active low; it clears the
// counts, flags and controller, and only entries below the counts are ever read.
module colour_keyed_pixel_labeler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_func,
    input  logic [ckpl_pkg::RCOL_W-1:0]   i_region_colour,
    input  logic [ckpl_pkg::COLOUR_W-1:0] i_terrain_colour,
    input  logic [ckpl_pkg::VAR_W-1:0]    i_terrain_variant,
    output logic                          o_done,
    output logic [2:0]                    o_status,
    output logic [ckpl_pkg::CNT_W-1:0]    o_region_index,
    output logic [ckpl_pkg::VAR_W-1:0]    o_variant_out,
    output logic                          o_region_unknown,
    output logic                          o_terrain_unknown,
    output logic [ckpl_pkg::CNT_W-1:0]    o_missing_count,
    output logic                          o_frame_ok
);
    import ckpl_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // From the datapath, the controller only sees the scan-done status and the latched function.
    ckpl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // The datapath owns both tables, the scan engine and the result registers.
    ckpl_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_func            (i_func),
        .i_region_colour   (i_region_colour),
        .i_terrain_colour  (i_terrain_colour),
        .i_terrain_variant (i_terrain_variant),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_region_index    (o_region_index),
        .o_variant_out     (o_variant_out),
        .o_region_unknown  (o_region_unknown),
        .o_terrain_unknown (o_terrain_unknown),
        .o_missing_count   (o_missing_count),
        .o_frame_ok        (o_frame_ok)
    );
endmodule

>>> design/ckpl_checker.sv
// Port-level checker for the pixel labeler and its bind to the top level.
module ckpl_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_done,
    input logic [2:0]                 o_status,
    input logic [ckpl_pkg::CNT_W-1:0] o_region_index,
    input logic                       o_region_unknown,
    input logic                       o_terrain_unknown,
    input logic [ckpl_pkg::CNT_W-1:0] o_missing_count,
    input logic                       o_frame_ok
);
    import ckpl_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after a command transfer");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe lasted more than one cycle");

    a_refused_no_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != STAT_OK)) |-> (o_region_index == '0))
        else $error("refused item carries a region index");

    a_frame_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_frame_ok) |->
            (!o_region_unknown && !o_terrain_unknown && (o_missing_count == '0)))
        else $error("frame reported clean with faults");
endmodule

bind colour_keyed_pixel_labeler ckpl_checker u_ckpl_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_done            (o_done),
    .o_status          (o_status),
    .o_region_index    (o_region_index),
    .o_region_unknown  (o_region_unknown),
    .o_terrain_unknown (o_terrain_unknown),
    .o_missing_count   (o_missing_count),
    .o_frame_ok        (o_frame_ok)
);

>>> sim/tb_top.sv
// Self-checking testbench for the colour-keyed pixel labeler: queued stimulus, label predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ckpl_pkg::*;

    // One command for the block. A sync entry is not driven: it holds the
    // sender until every expected result has come back.
    typedef struct {
        t_func       fn;
        bit [31:0]   rcol;
        bit [23:0]   tcol;
        bit [7:0]    tvar;
        bit          sync;
        int          idle_pct;
    } label_cmd_t;

    typedef struct {
        bit [2:0]  status;
        bit [12:0] index;
        bit [7:0]  variant;
        bit        r_unk;
        bit        t_unk;
        bit [12:0] missing;
        bit        ok;
    } label_res_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_func = '0;
    logic [31:0] i_region_colour = '0;
    logic [23:0] i_terrain_colour = '0;
    logic [7:0]  i_terrain_variant = '0;
    logic        o_done;
    logic [2:0]  o_status;
    logic [12:0] o_region_index;
    logic [7:0]  o_variant_out;
    logic        o_region_unknown;
    logic        o_terrain_unknown;
    logic [12:0] o_missing_count;
    logic        o_frame_ok;

    colour_keyed_pixel_labeler i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_func            (i_func),
        .i_region_colour   (i_region_colour),
        .i_terrain_colour  (i_terrain_colour),
        .i_terrain_variant (i_terrain_variant),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_region_index    (o_region_index),
        .o_variant_out     (o_variant_out),
        .o_region_unknown  (o_region_unknown),
        .o_terrain_unknown (o_terrain_unknown),
        .o_missing_count   (o_missing_count),
        .o_frame_ok        (o_frame_ok)
    );

    label_cmd_t cmd_q[$];
    label_res_t label_q[$];
    label_cmd_t cur_cmd;
    int         fail_cnt = 0;

    // Shadow copy of the block's tables, counts and frame flags.
    bit [23:0] shadow_regions[MAX_REGIONS];
    int        shadow_rcount = 0;
    bit [23:0] shadow_tkeys[MAX_TERRAINS];
    bit [7:0]  shadow_tvals[MAX_TERRAINS];
    int        shadow_tcount = 0;
    bit        shadow_seen[MAX_REGIONS];
    bit        shadow_any_r = 1'b0;
    bit        shadow_any_t = 1'b0;

    // Colours the generator has issued valid adds for, used to aim lookups at hits.
    bit [23:0] gen_regions[$];
    bit [23:0] gen_terrains[$];

    // Works out the result of one accepted command and updates the shadow state.
    function automatic label_res_t label_lookup(label_cmd_t c);
        label_res_t r;
        int ridx;
        int tslot;
        r = '{default: 0};
        ridx = 0;
        tslot = 0;
        if (c.fn == FUNC_PIXEL || c.fn == FUNC_ADD_REGION) begin
            if (c.rcol != 0 && c.rcol <= 32'hFFFFFF) begin
                for (int i = 0; i < shadow_rcount; i++) begin
                    if (shadow_regions[i] == c.rcol[23:0] && ridx == 0) ridx = i + 1;
                end
            end
        end
        for (int i = 0; i < shadow_tcount; i++) begin
            if (shadow_tkeys[i] == c.tcol && tslot == 0) tslot = i + 1;
        end
        case (c.fn)
            FUNC_ADD_REGION: begin
                if (shadow_rcount >= MAX_REGIONS) begin
                    r.status = STAT_REGION_FULL;
                end else if (c.rcol == 0 || c.rcol > 32'hFFFFFF) begin
                    r.status = STAT_INVALID;
                end else if (ridx != 0) begin
                    r.status = STAT_DUPLICATE;
                end else begin
                    shadow_regions[shadow_rcount] = c.rcol[23:0];
                    shadow_rcount++;
                    r.index = 13'(shadow_rcount);
                end
            end
            FUNC_ADD_TERRAIN: begin
                if (tslot != 0) begin
                    shadow_tvals[tslot-1] = c.tvar;
                end else if (shadow_tcount >= MAX_TERRAINS) begin
                    r.status = STAT_TERRAIN_FULL;
                end else begin
                    shadow_tkeys[shadow_tcount] = c.tcol;
                    shadow_tvals[shadow_tcount] = c.tvar;
                    shadow_tcount++;
                end
            end
            FUNC_PIXEL: begin
                if (tslot != 0) begin
                    r.variant = shadow_tvals[tslot-1];
                end else begin
                    r.t_unk = 1'b1;
                    shadow_any_t = 1'b1;
                end
                r.index = 13'(ridx);
                if (ridx != 0) begin
                    shadow_seen[ridx-1] = 1'b1;
                end else begin
                    r.r_unk = 1'b1;
                    shadow_any_r = 1'b1;
                end
            end
            default: begin
                for (int i = 0; i < shadow_rcount; i++) begin
                    if (!shadow_seen[i]) r.missing++;
                end
                r.r_unk = shadow_any_r;
                r.t_unk = shadow_any_t;
                r.ok = !shadow_any_r && !shadow_any_t && r.missing == 0;
                shadow_any_r = 1'b0;
                shadow_any_t = 1'b0;
                foreach (shadow_seen[i]) shadow_seen[i] = 1'b0;
            end
        endcase
        return r;
    endfunction

    task automatic push_cmd(t_func fn, bit [31:0] rc, bit [23:0] tc, bit [7:0] tv, int idle);
        label_cmd_t c;
        c.fn = fn;
        c.rcol = rc;
        c.tcol = tc;
        c.tvar = tv;
        c.sync = 1'b0;
        c.idle_pct = idle;
        cmd_q.push_back(c);
    endtask

    task automatic push_sync();
        label_cmd_t c;
        c = '{fn: FUNC_FINISH, rcol: 0, tcol: 0, tvar: 0, sync: 1'b1, idle_pct: 0};
        cmd_q.push_back(c);
    endtask

    // Adds a region colour and remembers it when it is a fresh, valid one.
    task automatic gen_add_region(bit [31:0] rc, int idle);
        bit known;
        known = 1'b0;
        foreach (gen_regions[i]) if (gen_regions[i] == rc) known = 1'b1;
        if (!known && rc != 0 && rc <= 32'hFFFFFF) gen_regions.push_back(rc[23:0]);
        push_cmd(FUNC_ADD_REGION, rc, 24'($urandom), 8'($urandom), idle);
    endtask

    task automatic gen_add_terrain(bit [23:0] tc, bit [7:0] tv, int idle);
        bit known;
        known = 1'b0;
        foreach (gen_terrains[i]) if (gen_terrains[i] == tc) known = 1'b1;
        if (!known && gen_terrains.size() < MAX_TERRAINS) gen_terrains.push_back(tc);
        push_cmd(FUNC_ADD_TERRAIN, $urandom, tc, tv, idle);
    endtask

    function automatic bit [23:0] pick_terrain();
        if (gen_terrains.size() == 0 || $urandom_range(99) < 25) return 24'($urandom);
        return gen_terrains[$urandom_range(gen_terrains.size() - 1)];
    endfunction

    // A clean frame: every stored region is hit once with a known terrain colour.
    task automatic gen_clean_frame(int idle);
        push_cmd(FUNC_FINISH, $urandom, 24'($urandom), 8'($urandom), idle);
        foreach (gen_regions[i]) begin
            push_cmd(FUNC_PIXEL, {8'h00, gen_regions[i]},
                     gen_terrains[$urandom_range(gen_terrains.size() - 1)],
                     8'($urandom), idle);
        end
        push_cmd(FUNC_FINISH, $urandom, 24'($urandom), 8'($urandom), idle);
    endtask

    // Mostly lookups that hit stored colours, with adds, misses and frame ends mixed in.
    task automatic gen_random(int count, int idle);
        int sel;
        bit [31:0] rc;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 15) begin
                if (gen_regions.size() < 60 && $urandom_range(99) < 70) begin
                    gen_add_region({8'h00, 24'($urandom)}, idle);
                end else if ($urandom_range(1) == 1 && gen_regions.size() > 0) begin
                    gen_add_region({8'h00, gen_regions[$urandom_range(gen_regions.size() - 1)]},
                                   idle);
                end else begin
                    gen_add_region($urandom | 32'h0100_0000, idle);
                end
            end else if (sel < 27) begin
                gen_add_terrain(pick_terrain(), 8'($urandom), idle);
            end else if (sel < 90) begin
                if (gen_regions.size() > 0 && $urandom_range(99) < 80) begin
                    rc = {8'h00, gen_regions[$urandom_range(gen_regions.size() - 1)]};
                end else begin
                    rc = $urandom;
                end
                push_cmd(FUNC_PIXEL, rc, pick_terrain(), 8'($urandom), idle);
            end else begin
                push_cmd(FUNC_FINISH, $urandom, 24'($urandom), 8'($urandom), idle);
            end
        end
    endtask

    // Stimulus plan, built before reset is released.
    initial begin
        // Directed part: empty tables, colour extremes, refusals and overwrites.
        push_cmd(FUNC_FINISH, 32'hFFFF_FFFF, 24'hFFFFFF, 8'hFF, 0);
        push_cmd(FUNC_PIXEL, 32'h0000_0000, 24'h000000, 8'h00, 0);
        push_cmd(FUNC_FINISH, 32'h0, 24'h0, 8'h0, 0);
        gen_add_region(32'h0000_0000, 0);
        gen_add_region(32'h0100_0000, 0);
        gen_add_region(32'hFFFF_FFFF, 0);
        gen_add_region(32'h00FF_FFFF, 0);
        gen_add_region(32'h0000_0001, 0);
        gen_add_region(32'h0000_0001, 0);
        gen_add_region(32'h00FF_FFFF, 0);
        gen_add_terrain(24'h000000, 8'hFF, 0);
        gen_add_terrain(24'hFFFFFF, 8'h00, 0);
        gen_add_terrain(24'hFFFFFF, 8'h5A, 0);
        push_cmd(FUNC_PIXEL, 32'h00FF_FFFF, 24'h000000, 8'h00, 0);
        push_cmd(FUNC_PIXEL, 32'h0000_0001, 24'hFFFFFF, 8'hFF, 0);
        push_cmd(FUNC_FINISH, 32'h0, 24'h0, 8'h0, 0);
        push_cmd(FUNC_PIXEL, 32'h0000_0001, 24'h123456, 8'h00, 0);
        push_cmd(FUNC_PIXEL, 32'h8000_0001, 24'h000000, 8'h00, 0);
        push_cmd(FUNC_PIXEL, 32'h0000_0000, 24'hFFFFFF, 8'h00, 0);
        push_cmd(FUNC_FINISH, 32'h0, 24'h0, 8'h0, 0);
        push_sync();

        // Random phases with different sender gap rates.
        gen_random(90, 0);
        gen_clean_frame(0);
        push_sync();
        gen_random(90, 55);
        push_sync();
        gen_random(80, 38);

        // Fill the terrain table, then an accepted overwrite and a refused new key.
        while (gen_terrains.size() < MAX_TERRAINS)
            gen_add_terrain(24'($urandom), 8'($urandom), 0);
        gen_add_terrain(24'hFFFFFF, 8'hC3, 0);
        push_cmd(FUNC_ADD_TERRAIN, 32'h0, 24'hABCDEF ^ 24'($urandom_range(1)), 8'h11, 0);
        gen_clean_frame(55);
        push_sync();
        gen_random(80, 0);
    end

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: a transfer takes place on an edge with start high and busy low.
    // The prediction is made at that edge, then the next command is presented.
    always @(posedge i_clk) begin
        bit present;
        present = 1'b0;
        if (i_rst_n) begin
            if (start && !busy) label_q.push_back(label_lookup(cur_cmd));
            if (start && busy) begin
                present = 1'b1;
            end else begin
                if (cmd_q.size() > 0 && cmd_q[0].sync && label_q.size() == 0 && !o_done)
                    void'(cmd_q.pop_front());
                if (cmd_q.size() > 0 && !cmd_q[0].sync
                    && $urandom_range(99) >= cmd_q[0].idle_pct) begin
                    cur_cmd = cmd_q.pop_front();
                    present = 1'b1;
                    i_func            <= cur_cmd.fn;
                    i_region_colour   <= cur_cmd.rcol;
                    i_terrain_colour  <= cur_cmd.tcol;
                    i_terrain_variant <= cur_cmd.tvar;
                end
            end
        end
        start <= present;
    end

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    // Monitor: every strobe is matched against the oldest prediction.
    always @(posedge i_clk) begin
        label_res_t e;
        if (i_rst_n && o_done) begin
            if (label_q.size() == 0) begin
                $error("result with no prediction waiting");
                fail_cnt++;
            end else begin
                e = label_q.pop_front();
                check_field("status", int'(e.status), int'(o_status));
                check_field("region_index", int'(e.index), int'(o_region_index));
                check_field("variant_out", int'(e.variant), int'(o_variant_out));
                check_field("region_unknown", int'(e.r_unk), int'(o_region_unknown));
                check_field("terrain_unknown", int'(e.t_unk), int'(o_terrain_unknown));
                check_field("missing_count", int'(e.missing), int'(o_missing_count));
                check_field("frame_ok", int'(e.ok), int'(o_frame_ok));
            end
        end
    end

    // End of run: all commands sent, all results back, then a short tail.
    initial begin
        wait (i_rst_n);
        wait (cmd_q.size() == 0 && !start && label_q.size() == 0);
        repeat (200) @(posedge i_clk);
        if (fail_cnt == 0 && label_q.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("tb_top failed");
        $finish;
    end

endmodule
